FILE: sv/lqra_pkg.sv
// Shared constants, codes and control types of the link quality rate advisor.
package lqra_pkg;

  // Frames between two evaluations.
  localparam int unsigned EVAL_INTERVAL = 60;
  localparam int unsigned FC_W          = 6;
  localparam logic [FC_W-1:0] EVAL_CNT  = FC_W'(EVAL_INTERVAL);

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [20:0] MIN_RATE = 21'd2000;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // advised / running ratio (x100) at which the percent saturates
  localparam logic [15:0] PCT_SAT_Q = 16'd32868;
  localparam logic [15:0] PCT_MAX   = 16'd32767;
  localparam logic [15:0] PCT_BASE  = 16'd100;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_ORIG_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EXC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_GOOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FAIR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_POOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd6;

  localparam logic [16:0] THR_EXC_RST  = 17'd655;
  localparam logic [16:0] THR_GOOD_RST = 17'd1966;
  localparam logic [16:0] THR_FAIR_RST = 17'd3277;
  localparam logic [16:0] THR_POOR_RST = 17'd6554;
  localparam logic [19:0] COOLDOWN_RST = 20'd1000;

  // Grades
  localparam logic [2:0] GR_EXCELLENT = 3'd0;
  localparam logic [2:0] GR_GOOD      = 3'd1;
  localparam logic [2:0] GR_FAIR      = 3'd2;
  localparam logic [2:0] GR_POOR      = 3'd3;
  localparam logic [2:0] GR_BAD       = 3'd4;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_DEGRADED = 2'd1;
  localparam logic [1:0] WARN_BAD      = 2'd2;

  localparam logic [1:0] DIR_DOWN = 2'b11;
  localparam logic [1:0] DIR_HOLD = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;

  // Serial divider geometry
  localparam int unsigned DIV_Q_W   = 17;
  localparam int unsigned DIV_DEN_W = 34;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_DELTA    = 5'd1;
  localparam op_t OP_DIV_LOSS = 5'd2;
  localparam op_t OP_X_LOSS   = 5'd3;
  localparam op_t OP_MUL      = 5'd4;
  localparam op_t OP_W_LOSS   = 5'd5;
  localparam op_t OP_DIV_REC  = 5'd6;
  localparam op_t OP_X_REC    = 5'd7;
  localparam op_t OP_W_REC    = 5'd8;
  localparam op_t OP_DIV_EFF  = 5'd9;
  localparam op_t OP_W_EFF    = 5'd10;
  localparam op_t OP_X_SCORE  = 5'd11;
  localparam op_t OP_W_GRADE  = 5'd12;
  localparam op_t OP_X_ADV    = 5'd13;
  localparam op_t OP_W_ADV    = 5'd14;
  localparam op_t OP_DIR      = 5'd15;
  localparam op_t OP_DIV_PCT  = 5'd16;
  localparam op_t OP_W_PCT    = 5'd17;
  localparam op_t OP_LOAD     = 5'd18;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic eval_hit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/lqra_if.sv
// Handshake channel interfaces: frame counters in, advice out, register writes.
interface lqra_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] video_count;
  logic [31:0] parity_count;
  logic [31:0] recovered_count;
  logic [31:0] unrecovered_count;
  logic [31:0] time_ms;

  modport source (output valid, video_count, parity_count, recovered_count,
                  unrecovered_count, time_ms, input ready);
  modport sink (input valid, video_count, parity_count, recovered_count,
                unrecovered_count, time_ms, output ready);
endinterface

interface lqra_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         grade;
  logic [16:0]        loss_avg;
  logic [16:0]        recovery_rate;
  logic [16:0]        parity_efficiency;
  logic [20:0]        advised_bitrate;
  logic               cut_bitrate;
  logic               more_parity;
  logic               keyframe_request;
  logic               grade_changed;
  logic [1:0]         warning_level;
  logic signed [1:0]  rate_direction;
  logic signed [15:0] rate_change_pct;

  modport source (output valid, grade, loss_avg, recovery_rate, parity_efficiency,
                  advised_bitrate, cut_bitrate, more_parity, keyframe_request,
                  grade_changed, warning_level, rate_direction, rate_change_pct,
                  input ready);
  modport sink (input valid, grade, loss_avg, recovery_rate, parity_efficiency,
                advised_bitrate, cut_bitrate, more_parity, keyframe_request,
                grade_changed, warning_level, rate_direction, rate_change_pct,
                output ready);
endinterface

interface lqra_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/link_quality_rate_advisor.sv
// Top level of the link quality rate advisor: sequencer, datapath and channel wiring.
//
// One frame record (cumulative video, parity, recovered and unrecovered packet
// counts plus a millisecond time) is taken per input transfer. Most frames only
// advance the frame counter and leave the sequencer idle; every 60th frame runs a
// full evaluation and yields one result transfer. The next frame can be taken as
// soon as the result is presented. Evaluation time is set mostly by the shared
// serial divider: four quotients (loss, FEC recovery and parity efficiency in
// unsigned Q1.16, rate change percent as an integer, each 17 quotient bits
// wide), and 17 further steps, among them a constant-reciprocal divide by ten
// for the two averages, the score and the advice. The input side is blocked
// while an evaluation runs. The result sits in an output register, so the next
// frame is accepted while it waits; a second result waits for the first to
// drain. Configuration writes are always taken (ready held high) and must be
// made only while the block is idle; register indexes 0..6 are original bitrate,
// running bitrate, the four grade thresholds and the keyframe cooldown; other
// indexes are dropped and data is cut to the register width.
module link_quality_rate_advisor (
  input  logic     clk_i,
  input  logic     rst_ni,
  lqra_in_if.sink  in_i,
  lqra_out_if.source out_o,
  lqra_cfg_if.sink cfg_i
);

  lqra_pkg::cmd_t  cmd;
  lqra_pkg::stat_t stat;
  logic            in_ready;

  // configuration is a plain register write, never back-pressured
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  lqra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lqra_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .video_count_i       (in_i.video_count),
    .parity_count_i      (in_i.parity_count),
    .recovered_count_i   (in_i.recovered_count),
    .unrecovered_count_i (in_i.unrecovered_count),
    .time_ms_i           (in_i.time_ms),
    .cfg_we_i            (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .grade_o             (out_o.grade),
    .loss_avg_o          (out_o.loss_avg),
    .recovery_rate_o     (out_o.recovery_rate),
    .parity_efficiency_o (out_o.parity_efficiency),
    .advised_bitrate_o   (out_o.advised_bitrate),
    .cut_bitrate_o       (out_o.cut_bitrate),
    .more_parity_o       (out_o.more_parity),
    .keyframe_request_o  (out_o.keyframe_request),
    .grade_changed_o     (out_o.grade_changed),
    .warning_level_o     (out_o.warning_level),
    .rate_direction_o    (out_o.rate_direction),
    .rate_change_pct_o   (out_o.rate_change_pct)
  );

endmodule

FILE: sv/lqra_div.sv
// Restoring serial divider: one quotient bit per cycle, 17-bit quotient.
module lqra_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] hi_i,   // upper dividend part, must be below den_i
  input  logic [16:0] lo_i,   // lower dividend bits, shifted in MSB first
  input  logic [33:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(lqra_pkg::DIV_Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lqra_pkg::DIV_Q_W - 1);

  logic [33:0]      rem_q, rem_d;
  logic [16:0]      lo_q, lo_d;
  logic [16:0]      quo_q, quo_d;
  logic [33:0]      den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [34:0]      trial;
  logic [34:0]      diff;
  logic             fits;

  assign trial = {rem_q, lo_q[16]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = hi_i;
      lo_d   = lo_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[33:0] : trial[33:0];
      lo_d  = {lo_q[15:0], 1'b0};
      quo_d = {quo_q[15:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/lqra_ctrl.sv
// Sequencer: accepts frames and steps the datapath through one evaluation.
module lqra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lqra_pkg::stat_t      stat_i,
  output lqra_pkg::cmd_t       cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DELTA = 5'd1;
  localparam logic [4:0] ST_DIVL  = 5'd2;
  localparam logic [4:0] ST_WTL   = 5'd3;
  localparam logic [4:0] ST_XL    = 5'd4;
  localparam logic [4:0] ST_ML    = 5'd5;
  localparam logic [4:0] ST_WL    = 5'd6;
  localparam logic [4:0] ST_DIVR  = 5'd7;
  localparam logic [4:0] ST_WTR   = 5'd8;
  localparam logic [4:0] ST_XR    = 5'd9;
  localparam logic [4:0] ST_MR    = 5'd10;
  localparam logic [4:0] ST_WR    = 5'd11;
  localparam logic [4:0] ST_DIVE  = 5'd12;
  localparam logic [4:0] ST_WTE   = 5'd13;
  localparam logic [4:0] ST_WE    = 5'd14;
  localparam logic [4:0] ST_XS    = 5'd15;
  localparam logic [4:0] ST_MS    = 5'd16;
  localparam logic [4:0] ST_WG    = 5'd17;
  localparam logic [4:0] ST_XA    = 5'd18;
  localparam logic [4:0] ST_MA    = 5'd19;
  localparam logic [4:0] ST_WA    = 5'd20;
  localparam logic [4:0] ST_DIR   = 5'd21;
  localparam logic [4:0] ST_DIVP  = 5'd22;
  localparam logic [4:0] ST_WTP   = 5'd23;
  localparam logic [4:0] ST_WP    = 5'd24;
  localparam logic [4:0] ST_LOAD  = 5'd25;

  logic [4:0] state_q, state_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = in_xfer;
    cmd_o.op     = lqra_pkg::OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && stat_i.eval_hit) state_d = ST_DELTA;
      end
      ST_DELTA: begin cmd_o.op = lqra_pkg::OP_DELTA;    state_d = ST_DIVL; end
      ST_DIVL:  begin cmd_o.op = lqra_pkg::OP_DIV_LOSS; state_d = ST_WTL;  end
      ST_WTL: begin
        if (stat_i.div_done) state_d = ST_XL;
      end
      ST_XL:    begin cmd_o.op = lqra_pkg::OP_X_LOSS;   state_d = ST_ML;   end
      ST_ML:    begin cmd_o.op = lqra_pkg::OP_MUL;      state_d = ST_WL;   end
      ST_WL:    begin cmd_o.op = lqra_pkg::OP_W_LOSS;   state_d = ST_DIVR; end
      ST_DIVR:  begin cmd_o.op = lqra_pkg::OP_DIV_REC;  state_d = ST_WTR;  end
      ST_WTR: begin
        if (stat_i.div_done) state_d = ST_XR;
      end
      ST_XR:    begin cmd_o.op = lqra_pkg::OP_X_REC;    state_d = ST_MR;   end
      ST_MR:    begin cmd_o.op = lqra_pkg::OP_MUL;      state_d = ST_WR;   end
      ST_WR:    begin cmd_o.op = lqra_pkg::OP_W_REC;    state_d = ST_DIVE; end
      ST_DIVE:  begin cmd_o.op = lqra_pkg::OP_DIV_EFF;  state_d = ST_WTE;  end
      ST_WTE: begin
        if (stat_i.div_done) state_d = ST_WE;
      end
      ST_WE:    begin cmd_o.op = lqra_pkg::OP_W_EFF;    state_d = ST_XS;   end
      ST_XS:    begin cmd_o.op = lqra_pkg::OP_X_SCORE;  state_d = ST_MS;   end
      ST_MS:    begin cmd_o.op = lqra_pkg::OP_MUL;      state_d = ST_WG;   end
      ST_WG:    begin cmd_o.op = lqra_pkg::OP_W_GRADE;  state_d = ST_XA;   end
      ST_XA:    begin cmd_o.op = lqra_pkg::OP_X_ADV;    state_d = ST_MA;   end
      ST_MA:    begin cmd_o.op = lqra_pkg::OP_MUL;      state_d = ST_WA;   end
      ST_WA:    begin cmd_o.op = lqra_pkg::OP_W_ADV;    state_d = ST_DIR;  end
      ST_DIR:   begin cmd_o.op = lqra_pkg::OP_DIR;      state_d = ST_DIVP; end
      ST_DIVP:  begin cmd_o.op = lqra_pkg::OP_DIV_PCT;  state_d = ST_WTP;  end
      ST_WTP: begin
        if (stat_i.div_done) state_d = ST_WP;
      end
      ST_WP:    begin cmd_o.op = lqra_pkg::OP_W_PCT;    state_d = ST_LOAD; end
      ST_LOAD: begin
        // hold until the output register is empty or being drained
        if (stat_i.out_free) begin
          cmd_o.op = lqra_pkg::OP_LOAD;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/lqra_dp.sv
// Datapath: registers, counter deltas, smoothing, grading, rate advice, output register.
module lqra_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lqra_pkg::cmd_t     cmd_i,
  output lqra_pkg::stat_t    stat_o,
  input  logic [31:0]        video_count_i,
  input  logic [31:0]        parity_count_i,
  input  logic [31:0]        recovered_count_i,
  input  logic [31:0]        unrecovered_count_i,
  input  logic [31:0]        time_ms_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         grade_o,
  output logic [16:0]        loss_avg_o,
  output logic [16:0]        recovery_rate_o,
  output logic [16:0]        parity_efficiency_o,
  output logic [20:0]        advised_bitrate_o,
  output logic               cut_bitrate_o,
  output logic               more_parity_o,
  output logic               keyframe_request_o,
  output logic               grade_changed_o,
  output logic [1:0]         warning_level_o,
  output logic signed [1:0]  rate_direction_o,
  output logic signed [15:0] rate_change_pct_o
);

  // configuration
  logic [19:0] orig_q, run_q, cd_q;
  logic [16:0] thr_exc_q, thr_good_q, thr_fair_q, thr_poor_q;

  // frame state
  logic [lqra_pkg::FC_W-1:0] fc_q, fc_inc;
  logic [31:0] vid_q, par_q, rec_q, unr_q, now_q;
  logic [31:0] prev_vid_q, prev_rec_q, prev_unr_q;
  logic [31:0] dr_q;
  logic [32:0] att_q;
  logic [33:0] exp_q;
  logic [16:0] loss_q, recs_q, eff_q, rr_q;
  logic [2:0]  grade_q, last_grade_q;
  logic        key_q, chg_q;
  logic [31:0] lastkf_q;
  logic [31:0] x_q;
  logic [63:0] prod_q;
  logic [20:0] adv_q;
  logic [1:0]  dir_q;
  logic        sat_q, ge_q;
  logic [26:0] pnum_q;
  logic [15:0] pct_q;

  // output register
  logic        ov_q;
  logic [2:0]  o_grade_q;
  logic [16:0] o_loss_q, o_rr_q, o_eff_q;
  logic [20:0] o_adv_q;
  logic        o_key_q, o_chg_q;
  logic [1:0]  o_dir_q;
  logic [15:0] o_pct_q;

  // divider hookup
  logic        div_start;
  logic [33:0] div_hi, div_den;
  logic [16:0] div_lo, div_quo;
  logic        div_done;

  // combinational helpers
  logic [31:0] dv, dr, du;
  logic [32:0] att;
  logic [20:0] q10;
  logic [2:0]  grade_n;
  logic [31:0] elapsed, cd_ext, cd3;
  logic        key_n;
  logic [3:0]  mult;
  logic [31:0] adv10, run9, run11;
  logic [39:0] adv100w, runsat;
  logic [20:0] pdiff;

  assign fc_inc = fc_q + 1'b1;

  assign stat_o.eval_hit = (fc_inc >= lqra_pkg::EVAL_CNT);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !ov_q || out_ready_i;

  assign dv  = vid_q - prev_vid_q;
  assign dr  = rec_q - prev_rec_q;
  assign du  = unr_q - prev_unr_q;
  assign att = {1'b0, dr} + {1'b0, du};

  assign q10 = prod_q[lqra_pkg::RECIP_SHIFT +: 21];

  // grade from the combined score
  always_comb begin
    if (q10 < {4'b0, thr_exc_q})       grade_n = lqra_pkg::GR_EXCELLENT;
    else if (q10 < {4'b0, thr_good_q}) grade_n = lqra_pkg::GR_GOOD;
    else if (q10 < {4'b0, thr_fair_q}) grade_n = lqra_pkg::GR_FAIR;
    else if (q10 < {4'b0, thr_poor_q}) grade_n = lqra_pkg::GR_POOR;
    else                               grade_n = lqra_pkg::GR_BAD;
  end

  assign elapsed = now_q - lastkf_q;
  assign cd_ext  = 32'(cd_q);
  assign cd3     = cd_ext * 32'd3;

  always_comb begin
    key_n = 1'b0;
    if (elapsed >= cd_ext) begin
      if (last_grade_q >= lqra_pkg::GR_POOR && grade_n <= lqra_pkg::GR_FAIR) begin
        key_n = 1'b1;
      end else if (grade_n == lqra_pkg::GR_BAD && last_grade_q != lqra_pkg::GR_BAD) begin
        key_n = 1'b1;
      end else if (loss_q > thr_poor_q && elapsed >= cd3) begin
        key_n = 1'b1;
      end
    end
  end

  always_comb begin
    case (grade_q)
      lqra_pkg::GR_EXCELLENT: mult = (run_q < orig_q) ? 4'd11 : 4'd10;
      lqra_pkg::GR_GOOD:      mult = 4'd9;
      lqra_pkg::GR_FAIR:      mult = 4'd7;
      lqra_pkg::GR_POOR:      mult = 4'd5;
      default:                mult = 4'd3;
    endcase
  end

  assign adv10   = 32'(adv_q) * 32'd10;
  assign run9    = 32'(run_q) * 32'd9;
  assign run11   = 32'(run_q) * 32'd11;
  assign adv100w = 40'(adv_q) * 40'd100;
  assign runsat  = 40'(run_q) * 40'(lqra_pkg::PCT_SAT_Q);
  assign pdiff   = {1'b0, run_q} - adv_q;

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_den   = '0;
    case (cmd_i.op)
      lqra_pkg::OP_DIV_LOSS: begin
        div_start = 1'b1;
        div_hi    = {2'b0, att_q[32:1]};
        div_lo    = {att_q[0], 16'b0};
        div_den   = exp_q;
      end
      lqra_pkg::OP_DIV_REC: begin
        div_start = 1'b1;
        div_hi    = {3'b0, dr_q[31:1]};
        div_lo    = {dr_q[0], 16'b0};
        div_den   = {1'b0, att_q};
      end
      lqra_pkg::OP_DIV_EFF: begin
        div_start = 1'b1;
        div_hi    = {3'b0, rec_q[31:1]};
        div_lo    = {rec_q[0], 16'b0};
        div_den   = {2'b0, par_q};
      end
      lqra_pkg::OP_DIV_PCT: begin
        div_start = 1'b1;
        div_hi    = {24'b0, pnum_q[26:17]};
        div_lo    = pnum_q[16:0];
        div_den   = {14'b0, run_q};
      end
      default: div_start = 1'b0;
    endcase
  end

  lqra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_q       <= '0;
      run_q        <= '0;
      thr_exc_q    <= lqra_pkg::THR_EXC_RST;
      thr_good_q   <= lqra_pkg::THR_GOOD_RST;
      thr_fair_q   <= lqra_pkg::THR_FAIR_RST;
      thr_poor_q   <= lqra_pkg::THR_POOR_RST;
      cd_q         <= lqra_pkg::COOLDOWN_RST;
      fc_q         <= '0;
      prev_vid_q   <= '0;
      prev_rec_q   <= '0;
      prev_unr_q   <= '0;
      loss_q       <= '0;
      recs_q       <= '0;
      eff_q        <= '0;
      last_grade_q <= lqra_pkg::GR_EXCELLENT;
      lastkf_q     <= '0;
      ov_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lqra_pkg::REG_ORIG_RATE: orig_q     <= cfg_data_i;
          lqra_pkg::REG_RUN_RATE:  run_q      <= cfg_data_i;
          lqra_pkg::REG_THR_EXC:   thr_exc_q  <= cfg_data_i[16:0];
          lqra_pkg::REG_THR_GOOD:  thr_good_q <= cfg_data_i[16:0];
          lqra_pkg::REG_THR_FAIR:  thr_fair_q <= cfg_data_i[16:0];
          lqra_pkg::REG_THR_POOR:  thr_poor_q <= cfg_data_i[16:0];
          lqra_pkg::REG_COOLDOWN:  cd_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        fc_q <= stat_o.eval_hit ? '0 : fc_inc;
      end
      case (cmd_i.op)
        lqra_pkg::OP_DELTA: begin
          prev_vid_q <= vid_q;
          prev_rec_q <= rec_q;
          prev_unr_q <= unr_q;
        end
        lqra_pkg::OP_W_LOSS: begin
          if (exp_q != '0) loss_q <= q10[16:0];
        end
        lqra_pkg::OP_W_REC: begin
          if (att_q != '0) recs_q <= q10[16:0];
        end
        lqra_pkg::OP_W_EFF: begin
          if (par_q != '0) eff_q <= (rec_q >= par_q) ? lqra_pkg::ONE_Q16 : div_quo;
        end
        lqra_pkg::OP_W_GRADE: begin
          last_grade_q <= grade_n;
          if (key_n) lastkf_q <= now_q;
        end
        default: ;
      endcase
      if (cmd_i.op == lqra_pkg::OP_LOAD) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vid_q <= video_count_i;
      par_q <= parity_count_i;
      rec_q <= recovered_count_i;
      unr_q <= unrecovered_count_i;
      now_q <= time_ms_i;
    end
    case (cmd_i.op)
      lqra_pkg::OP_DELTA: begin
        dr_q  <= dr;
        att_q <= att;
        exp_q <= {2'b0, dv} + {1'b0, att};
      end
      lqra_pkg::OP_X_LOSS: x_q <= 32'(loss_q) * 32'd7 + 32'(div_quo) * 32'd3 + 32'd5;
      lqra_pkg::OP_X_REC:  x_q <= 32'(recs_q) * 32'd7 + 32'(div_quo) * 32'd3 + 32'd5;
      lqra_pkg::OP_X_SCORE: begin
        x_q <= 32'(loss_q) * 32'd6 + 32'(lqra_pkg::ONE_Q16 - rr_q) * 32'd4 + 32'd5;
      end
      lqra_pkg::OP_X_ADV:  x_q <= 32'(orig_q) * 32'(mult);
      lqra_pkg::OP_MUL:    prod_q <= 64'(x_q) * 64'(lqra_pkg::RECIP10);
      lqra_pkg::OP_W_REC:  rr_q <= (att_q != '0) ? q10[16:0] : lqra_pkg::ONE_Q16;
      lqra_pkg::OP_W_GRADE: begin
        grade_q <= grade_n;
        key_q   <= key_n;
        chg_q   <= (grade_n != last_grade_q);
      end
      lqra_pkg::OP_W_ADV: adv_q <= (q10 < lqra_pkg::MIN_RATE) ? lqra_pkg::MIN_RATE : q10;
      lqra_pkg::OP_DIR: begin
        if (adv10 < run9)       dir_q <= lqra_pkg::DIR_DOWN;
        else if (adv10 > run11) dir_q <= lqra_pkg::DIR_UP;
        else                    dir_q <= lqra_pkg::DIR_HOLD;
        sat_q  <= (adv100w >= runsat);
        ge_q   <= (adv_q >= {1'b0, run_q});
        pnum_q <= (adv_q >= {1'b0, run_q}) ? adv100w[26:0]
                                           : 27'(32'(pdiff) * 32'd100);
      end
      lqra_pkg::OP_W_PCT: begin
        if (run_q == '0)  pct_q <= '0;
        else if (sat_q)   pct_q <= lqra_pkg::PCT_MAX;
        else if (ge_q)    pct_q <= div_quo[15:0] - lqra_pkg::PCT_BASE;
        else              pct_q <= 16'd0 - div_quo[15:0];
      end
      lqra_pkg::OP_LOAD: begin
        o_grade_q <= grade_q;
        o_loss_q  <= loss_q;
        o_rr_q    <= rr_q;
        o_eff_q   <= eff_q;
        o_adv_q   <= adv_q;
        o_key_q   <= key_q;
        o_chg_q   <= chg_q;
        o_dir_q   <= dir_q;
        o_pct_q   <= pct_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o         = ov_q;
  assign grade_o             = o_grade_q;
  assign loss_avg_o          = o_loss_q;
  assign recovery_rate_o     = o_rr_q;
  assign parity_efficiency_o = o_eff_q;
  assign advised_bitrate_o   = o_adv_q;
  assign cut_bitrate_o       = (o_grade_q >= lqra_pkg::GR_FAIR);
  assign more_parity_o       = (o_grade_q >= lqra_pkg::GR_FAIR);
  assign keyframe_request_o  = o_key_q;
  assign grade_changed_o     = o_chg_q;
  assign warning_level_o     = (o_grade_q == lqra_pkg::GR_BAD)  ? lqra_pkg::WARN_BAD :
                               (o_grade_q == lqra_pkg::GR_POOR) ? lqra_pkg::WARN_DEGRADED :
                                                                  lqra_pkg::WARN_NONE;
  assign rate_direction_o    = $signed(o_dir_q);
  assign rate_change_pct_o   = $signed(o_pct_q);

endmodule
